// ===== rtl/core/rcsd_pkg.sv =====
`timescale 1ns / 1ps

package rcsd_pkg;

   localparam int PulseWidth  = 16;
   localparam int RegWidth    = 16;
   localparam int BandWidth   = 15;
   localparam int RegCount    = 8;
   localparam int RegIdxWidth = $clog2(RegCount);
   localparam int StickWidth  = 17;
   localparam int ProdWidth   = 35;
   localparam int QuotWidth   = ProdWidth - 8;

   localparam logic signed [QuotWidth-1:0] StickOne = QuotWidth'(16384);
   localparam logic signed [QuotWidth-1:0] StickNeg = -QuotWidth'(16384);
   localparam logic signed [QuotWidth-1:0] LeftMax  = QuotWidth'(13107);
   localparam logic signed [QuotWidth-1:0] LeftMin  = '0;
   localparam logic signed [15:0]          PiThresh = 16'sd6553;
   localparam logic [ProdWidth-1:0]        RoundHalf = ProdWidth'(128);

   localparam logic [RegWidth-1:0]  RstRightVertCenter  = 16'd1485;
   localparam logic [RegWidth-1:0]  RstRightHorizCenter = 16'd1500;
   localparam logic [RegWidth-1:0]  RstLeftVertTrim     = 16'd1160;
   localparam logic [RegWidth-1:0]  RstRightVertGain    = 16'd11185;
   localparam logic [RegWidth-1:0]  RstRightHorizGain   = 16'd10486;
   localparam logic [RegWidth-1:0]  RstLeftVertGain     = 16'd5243;
   localparam logic [RegWidth-1:0]  RstToggleThreshold  = 16'd1000;
   localparam logic [BandWidth-1:0] RstNoiseBand        = 15'd164;

   typedef enum logic [1:0] {
      CH_RIGHT_VERT  = 2'd0,
      CH_RIGHT_HORIZ = 2'd1,
      CH_LEFT_VERT   = 2'd2,
      CH_TOGGLE      = 2'd3
   } channel_type;

   typedef enum logic [1:0] {
      PI_NONE         = 2'd0,
      PI_PROPORTIONAL = 2'd1,
      PI_INTEGRAL     = 2'd2
   } pi_target_type;

   typedef enum logic [RegIdxWidth-1:0] {
      REG_RIGHT_VERT_CENTER  = 3'd0,
      REG_RIGHT_HORIZ_CENTER = 3'd1,
      REG_LEFT_VERT_TRIM     = 3'd2,
      REG_RIGHT_VERT_GAIN    = 3'd3,
      REG_RIGHT_HORIZ_GAIN   = 3'd4,
      REG_LEFT_VERT_GAIN     = 3'd5,
      REG_TOGGLE_THRESHOLD   = 3'd6,
      REG_NOISE_BAND         = 3'd7
   } reg_index_type;

endpackage

// ===== rtl/core/rc_channel_scaler_deadband_unit.sv =====
`timescale 1ns / 1ps
// RC receiver channel scaler with noise band.
// req_*: one pulse width (us) per request; the channel is picked by an internal
//   round-robin counter: right vertical, right horizontal, left vertical, toggle.
//   A width of zero leaves that channel's value alone but still advances the
//   counter and still produces a response.
// rsp_*: one response per request with all held stick values (Q2.14), the
//   toggle flag, the PI target code and the PI constant (left vertical * 5).
// csr_*: write-only register port; write only while no request is in flight.
// Pipeline: input register, then result register; the scale multiply, clamp
//   and band compare sit between them. Throughput: one request per cycle while
//   the response is not stalled, set by that single multiply/compare stage.
// Stall: when rsp_tready is low the response holds and, if the input register
//   is empty, one more request is still taken into it; req_tready then drops.
// Reset: held values, toggle flag and channel counter clear to zero; the
//   registers return to their defaults; both pipeline stages empty.
module rc_channel_scaler_deadband_unit
   import rcsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // [15:0] pulse_width
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] right_vertical, [31:16] right_horizontal, [45:32] left_vertical,
   // [46] config_mode, [48:47] pi_target, [64:49] pi_constant, [71:65] zero
   output logic [71:0]            rsp_tdata,
   input  logic                   csr_wr_en,
   input  logic [RegIdxWidth-1:0] csr_index,
   input  logic [RegWidth-1:0]    csr_wdata
);

   logic [RegWidth-1:0]  rv_center_ff, rh_center_ff, lv_trim_ff;
   logic [RegWidth-1:0]  rv_gain_ff, rh_gain_ff, lv_gain_ff, tog_thresh_ff;
   logic [BandWidth-1:0] band_ff;

   logic                  in_valid_ff;
   logic [PulseWidth-1:0] in_width_ff;
   logic                  out_valid_ff;
   logic [71:0]           out_data_ff, out_data_in;

   channel_type       chan_ff, chan_in;
   logic signed [15:0] rv_ff, rv_in, rh_ff, rh_in;
   logic [13:0]        lv_ff, lv_in;
   logic               tog_ff, tog_in;

   logic                  out_ready;
   logic                  advance;

   logic [RegWidth-1:0]          center_sel, gain_sel;
   logic signed [QuotWidth-1:0]  lo_sel, hi_sel;
   logic signed [StickWidth-1:0] held_sel;
   logic signed [StickWidth:0]   diff;
   logic signed [ProdWidth-1:0]  prod;
   logic signed [QuotWidth-1:0]  quot, clamped;
   logic signed [StickWidth:0]   delta;
   logic [StickWidth:0]          delta_abs;
   logic                         take_new;
   logic signed [StickWidth-1:0] cand;
   pi_target_type                target;
   logic [15:0]                  pi_const;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_center_ff  <= RstRightVertCenter;
         rh_center_ff  <= RstRightHorizCenter;
         lv_trim_ff    <= RstLeftVertTrim;
         rv_gain_ff    <= RstRightVertGain;
         rh_gain_ff    <= RstRightHorizGain;
         lv_gain_ff    <= RstLeftVertGain;
         tog_thresh_ff <= RstToggleThreshold;
         band_ff       <= RstNoiseBand;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_RIGHT_VERT_CENTER:  rv_center_ff  <= csr_wdata;
            REG_RIGHT_HORIZ_CENTER: rh_center_ff  <= csr_wdata;
            REG_LEFT_VERT_TRIM:     lv_trim_ff    <= csr_wdata;
            REG_RIGHT_VERT_GAIN:    rv_gain_ff    <= csr_wdata;
            REG_RIGHT_HORIZ_GAIN:   rh_gain_ff    <= csr_wdata;
            REG_LEFT_VERT_GAIN:     lv_gain_ff    <= csr_wdata;
            REG_TOGGLE_THRESHOLD:   tog_thresh_ff <= csr_wdata;
            REG_NOISE_BAND:         band_ff       <= csr_wdata[BandWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_width_ff <= req_tdata[PulseWidth-1:0];
      end
   end

   // channel operand select
   always_comb begin
      case (chan_ff)
         CH_RIGHT_VERT: begin
            center_sel = rv_center_ff;
            gain_sel   = rv_gain_ff;
            lo_sel     = StickNeg;
            hi_sel     = StickOne;
            held_sel   = StickWidth'(rv_ff);
         end
         CH_RIGHT_HORIZ: begin
            center_sel = rh_center_ff;
            gain_sel   = rh_gain_ff;
            lo_sel     = StickNeg;
            hi_sel     = StickOne;
            held_sel   = StickWidth'(rh_ff);
         end
         default: begin
            center_sel = lv_trim_ff;
            gain_sel   = lv_gain_ff;
            lo_sel     = LeftMin;
            hi_sel     = LeftMax;
            held_sel   = $signed({3'b000, lv_ff});
         end
      endcase
   end

   // round to nearest, ties up: floor((d*g + 128) / 256)
   always_comb begin
      diff      = $signed({2'b00, in_width_ff}) - $signed({2'b00, center_sel});
      prod      = ProdWidth'(diff) * $signed({{(ProdWidth-RegWidth){1'b0}}, gain_sel});
      prod      = prod + $signed(RoundHalf);
      quot      = prod[ProdWidth-1:8];
      if (quot < lo_sel) begin
         clamped = lo_sel;
      end else if (quot > hi_sel) begin
         clamped = hi_sel;
      end else begin
         clamped = quot;
      end
      cand      = clamped[StickWidth-1:0];
      delta     = (StickWidth+1)'(held_sel) - (StickWidth+1)'(cand);
      delta_abs = delta[StickWidth] ? (StickWidth+1)'(-delta) : (StickWidth+1)'(delta);
      take_new  = (in_width_ff != '0) && (delta_abs > {3'b000, band_ff});
   end

   always_comb begin
      rv_in   = rv_ff;
      rh_in   = rh_ff;
      lv_in   = lv_ff;
      tog_in  = tog_ff;
      chan_in = channel_type'(chan_ff + 2'd1);
      case (chan_ff)
         CH_RIGHT_VERT:  if (take_new) rv_in = cand[15:0];
         CH_RIGHT_HORIZ: if (take_new) rh_in = cand[15:0];
         CH_LEFT_VERT:   if (take_new) lv_in = cand[13:0];
         CH_TOGGLE: begin
            if (in_width_ff != '0) tog_in = (in_width_ff < tog_thresh_ff);
         end
         default: ;
      endcase

      if (rv_in > PiThresh) begin
         target = PI_PROPORTIONAL;
      end else if (rh_in > PiThresh) begin
         target = PI_INTEGRAL;
      end else begin
         target = PI_NONE;
      end
      pi_const    = {lv_in, 2'b00} + {2'b00, lv_in};
      out_data_in = {7'd0, pi_const, target, tog_in, lv_in, rh_in, rv_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= CH_RIGHT_VERT;
         rv_ff   <= '0;
         rh_ff   <= '0;
         lv_ff   <= '0;
         tog_ff  <= 1'b0;
      end else if (advance) begin
         chan_ff <= chan_in;
         rv_ff   <= rv_in;
         rh_ff   <= rh_in;
         lv_ff   <= lv_in;
         tog_ff  <= tog_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      lv_ff <= 14'd13107)
      else $error("left vertical beyond 0.8");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      (rv_ff >= -16'sd16384) && (rv_ff <= 16'sd16384) &&
      (rh_ff >= -16'sd16384) && (rh_ff <= 16'sd16384))
      else $error("right stick value out of range");

   a_chan_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (chan_ff == channel_type'($past(chan_ff) + 2'd1)))
      else $error("channel counter did not step");

   a_chan_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chan_ff))
      else $error("channel counter moved without a request");

   a_rsp_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[48:47] != 2'd3))
      else $error("invalid PI target code");

endmodule

// ===== tb/rc_channel_scaler_deadband_unit_tb.sv =====
`timescale 1ns / 1ps

module rc_channel_scaler_deadband_unit_tb;
   import rcsd_pkg::*;

   // one response, msb first
   typedef struct packed {
      logic [6:0]         pad;
      logic [15:0]        pi_constant;
      pi_target_type      pi_target;
      logic               config_mode;
      logic [13:0]        left_vertical;
      logic signed [15:0] right_horizontal;
      logic signed [15:0] right_vertical;
   } readout_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // [15:0] pulse_width
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [15:0] right_vertical, [31:16] right_horizontal, [45:32] left_vertical,
   // [46] config_mode, [48:47] pi_target, [64:49] pi_constant, [71:65] zero
   logic [71:0]         rsp_tdata;
   logic                csr_wr_en = 1'b0;
   reg_index_type       csr_index = REG_RIGHT_VERT_CENTER;
   logic [RegWidth-1:0] csr_wdata = '0;

   // shadow of the block: registers, channel counter, held values
   logic [15:0]        reg_shadow [RegCount];
   channel_type        next_channel;
   logic signed [15:0] rv_held;
   logic signed [15:0] rh_held;
   logic [13:0]        lv_held;
   logic               toggle_held;

   readout_t due_readouts [$];

   int send_idle_pct = 22;
   int rsp_idle_pct  = 55;
   int rsp_hold_left = 0;
   int mismatch_count = 0;

   rc_channel_scaler_deadband_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // (width - center) * gain / 256, round half up, clamp
   function automatic int scale_clamp(logic [15:0] w, logic [15:0] ctr, logic [15:0] gain,
                                      int lo, int hi);
      longint diff;
      longint prod;
      longint quot;
      diff = longint'(w) - longint'(ctr);
      prod = diff * longint'(gain) + 128;
      quot = (prod >= 0) ? prod / 256 : -((-prod + 255) / 256);
      if (quot < lo) quot = lo;
      if (quot > hi) quot = hi;
      return int'(quot);
   endfunction

   function automatic int band_pass(int held, int cand);
      int d;
      d = held - cand;
      if (d < 0) d = -d;
      return (d > int'(reg_shadow[REG_NOISE_BAND])) ? cand : held;
   endfunction

   function automatic readout_t take_pulse(logic [15:0] w);
      readout_t r;
      if (w != 16'd0) begin
         case (next_channel)
            CH_RIGHT_VERT: rv_held = 16'(band_pass(rv_held,
               scale_clamp(w, reg_shadow[REG_RIGHT_VERT_CENTER],
                           reg_shadow[REG_RIGHT_VERT_GAIN], -16384, 16384)));
            CH_RIGHT_HORIZ: rh_held = 16'(band_pass(rh_held,
               scale_clamp(w, reg_shadow[REG_RIGHT_HORIZ_CENTER],
                           reg_shadow[REG_RIGHT_HORIZ_GAIN], -16384, 16384)));
            CH_LEFT_VERT: lv_held = 14'(band_pass(lv_held,
               scale_clamp(w, reg_shadow[REG_LEFT_VERT_TRIM],
                           reg_shadow[REG_LEFT_VERT_GAIN], 0, 13107)));
            default: toggle_held = (w < reg_shadow[REG_TOGGLE_THRESHOLD]);
         endcase
      end
      next_channel = channel_type'(2'(next_channel + 2'd1));
      r.pad = '0;
      r.right_vertical = rv_held;
      r.right_horizontal = rh_held;
      r.left_vertical = lv_held;
      r.config_mode = toggle_held;
      if (rv_held > PiThresh) r.pi_target = PI_PROPORTIONAL;
      else if (rh_held > PiThresh) r.pi_target = PI_INTEGRAL;
      else r.pi_target = PI_NONE;
      r.pi_constant = 16'(lv_held * 5);
      return r;
   endfunction

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_readout
      readout_t got;
      readout_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (due_readouts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with no request outstanding: %h", $time, rsp_tdata);
         end else begin
            want = due_readouts.pop_front();
            compare_field("right_vertical", want.right_vertical, got.right_vertical);
            compare_field("right_horizontal", want.right_horizontal, got.right_horizontal);
            compare_field("left_vertical", want.left_vertical, got.left_vertical);
            compare_field("config_mode", want.config_mode, got.config_mode);
            compare_field("pi_target", want.pi_target, got.pi_target);
            compare_field("pi_constant", want.pi_constant, got.pi_constant);
            compare_field("pad", want.pad, got.pad);
         end
      end
   end

   // receiver: random stalls, or a counted hold-off
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_pulse(logic [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      due_readouts.push_back(take_pulse(w));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (due_readouts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      reg_shadow[idx] = (idx == REG_NOISE_BAND) ? {1'b0, val[14:0]} : val;
   endtask

   function automatic logic [15:0] pick_reg(int lo, int hi);
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 16'h0000;
      if (sel == 1) return 16'hFFFF;
      return 16'($urandom_range(hi, lo));
   endfunction

   // mostly widths near the selected channel's center, some noise
   function automatic logic [15:0] pick_pulse();
      int sel;
      int base;
      int span;
      sel = $urandom_range(99);
      if (sel < 8) return 16'd0;
      if (sel < 20) return 16'($urandom());
      case (next_channel)
         CH_RIGHT_VERT:  base = reg_shadow[REG_RIGHT_VERT_CENTER];
         CH_RIGHT_HORIZ: base = reg_shadow[REG_RIGHT_HORIZ_CENTER];
         CH_LEFT_VERT:   base = reg_shadow[REG_LEFT_VERT_TRIM] + 200;
         default:        base = reg_shadow[REG_TOGGLE_THRESHOLD];
      endcase
      span = (sel < 60) ? 40 : 600;
      base = base + int'($urandom_range(2 * span)) - span;
      if (base < 1) base = 1;
      if (base > 65535) base = 65535;
      return 16'(base);
   endfunction

   task automatic test_reset_defaults();
      logic [15:0] pulses [] = '{
         16'd65535, 16'd1,     16'd65535, 16'd999,
         16'd0,     16'd0,     16'd0,     16'd0,
         16'd1485,  16'd1500,  16'd1,     16'd1000,
         16'd1488,  16'd65535, 16'd1400,  16'd65535,
         16'd2000,  16'd1000,  16'd65535, 16'd1};
      foreach (pulses[i]) send_pulse(pulses[i]);
      wait_drained();
   endtask

   // unit gain makes the band edge exact; gain 128 gives half-way ties
   task automatic test_exact_scaling();
      logic [15:0] first_pulses [] = '{
         16'd1,  16'd65534, 16'd5000, 16'd1,
         16'd11, 16'd1,     16'd100,  16'd65535,
         16'd12, 16'd65535, 16'd65535, 16'd0};
      logic [15:0] second_pulses [] = '{
         16'd1,     16'd1001, 16'd101,  16'd65534,
         16'd65535, 16'd999,  16'd65535, 16'd65535};
      write_reg(REG_RIGHT_VERT_CENTER, 16'd0);
      write_reg(REG_RIGHT_HORIZ_CENTER, 16'hFFFF);
      write_reg(REG_LEFT_VERT_TRIM, 16'd100);
      write_reg(REG_RIGHT_VERT_GAIN, 16'd256);
      write_reg(REG_RIGHT_HORIZ_GAIN, 16'd128);
      write_reg(REG_LEFT_VERT_GAIN, 16'd0);
      write_reg(REG_TOGGLE_THRESHOLD, 16'd0);
      write_reg(REG_NOISE_BAND, 16'd10);
      foreach (first_pulses[i]) send_pulse(first_pulses[i]);
      wait_drained();
      write_reg(REG_RIGHT_HORIZ_CENTER, 16'd1000);
      write_reg(REG_RIGHT_VERT_GAIN, 16'hFFFF);
      write_reg(REG_LEFT_VERT_GAIN, 16'hFFFF);
      write_reg(REG_TOGGLE_THRESHOLD, 16'hFFFF);
      write_reg(REG_NOISE_BAND, 16'd0);
      foreach (second_pulses[i]) send_pulse(second_pulses[i]);
      wait_drained();
      write_reg(REG_NOISE_BAND, 16'hFFFF);
      foreach (second_pulses[i]) send_pulse(second_pulses[i]);
      wait_drained();
   endtask

   task automatic randomize_regs();
      write_reg(REG_RIGHT_VERT_CENTER, pick_reg(900, 2100));
      write_reg(REG_RIGHT_HORIZ_CENTER, pick_reg(900, 2100));
      write_reg(REG_LEFT_VERT_TRIM, pick_reg(900, 1500));
      write_reg(REG_RIGHT_VERT_GAIN, pick_reg(2000, 16000));
      write_reg(REG_RIGHT_HORIZ_GAIN, pick_reg(2000, 16000));
      write_reg(REG_LEFT_VERT_GAIN, pick_reg(2000, 16000));
      write_reg(REG_TOGGLE_THRESHOLD, pick_reg(800, 2200));
      write_reg(REG_NOISE_BAND, pick_reg(0, 600));
   endtask

   // receiver holds off while the sender keeps offering requests
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      rsp_hold_left = 80;
      repeat (30) send_pulse(pick_pulse());
      wait_drained();
      send_idle_pct = saved_pct;
   endtask

   task automatic test_random_traffic();
      int send_pct [3] = '{22, 55, 0};
      int recv_pct [3] = '{55, 22, 0};
      for (int m = 0; m < 3; m++) begin
         send_idle_pct = send_pct[m];
         rsp_idle_pct = recv_pct[m];
         for (int p = 0; p < 4; p++) begin
            randomize_regs();
            repeat (100) send_pulse(pick_pulse());
            wait_drained();
         end
      end
   endtask

   initial begin
      reg_shadow[REG_RIGHT_VERT_CENTER]  = RstRightVertCenter;
      reg_shadow[REG_RIGHT_HORIZ_CENTER] = RstRightHorizCenter;
      reg_shadow[REG_LEFT_VERT_TRIM]     = RstLeftVertTrim;
      reg_shadow[REG_RIGHT_VERT_GAIN]    = RstRightVertGain;
      reg_shadow[REG_RIGHT_HORIZ_GAIN]   = RstRightHorizGain;
      reg_shadow[REG_LEFT_VERT_GAIN]     = RstLeftVertGain;
      reg_shadow[REG_TOGGLE_THRESHOLD]   = RstToggleThreshold;
      reg_shadow[REG_NOISE_BAND]         = {1'b0, RstNoiseBand};
      next_channel = CH_RIGHT_VERT;
      rv_held = '0;
      rh_held = '0;
      lv_held = '0;
      toggle_held = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_exact_scaling();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && due_readouts.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
